// ----- src/bpbcd_pkg.sv -----
// ----------------------------------------------------------------------------
// bpbcd_pkg
// Shared constants, beat types and state encoding of the binary to packed
// BCD converter.
// ----------------------------------------------------------------------------
package bpbcd_pkg;

  localparam int unsigned VALUE_W    = 64;  // binary input width
  localparam int unsigned COUNT_W    = 5;   // byte count field width
  localparam int unsigned INDEX_W    = 4;   // byte index field width
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned BCD_DIGITS = 20;  // decimal digits of a 64-bit value
  localparam int unsigned BCD_W      = BCD_DIGITS * DIGIT_W;
  localparam int unsigned BCD_PAIRS  = BCD_DIGITS / 2;
  localparam int unsigned STEP_W     = $clog2(VALUE_W);
  localparam int unsigned MAX_BYTES  = 16;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] byte_count;
  } in_beat_t;

  typedef struct packed {
    logic [INDEX_W-1:0] byte_index;
    logic [BYTE_W-1:0]  bcd_byte;
    logic               has_byte;
    logic               last;
    logic               overflow;
  } out_beat_t;

  // Status of the shift-add-3 core toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } dab_sts_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT
  } state_e;

endpackage

// ----- src/bpbcd_if.sv -----
// ----------------------------------------------------------------------------
// bpbcd_if
// Valid/ready channels carrying the input beat and the result beat.
// ----------------------------------------------------------------------------
interface bpbcd_in_if;
  logic                valid;
  logic                ready;
  bpbcd_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bpbcd_out_if;
  logic                 valid;
  logic                 ready;
  bpbcd_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/bpbcd_dabble.sv -----
// ----------------------------------------------------------------------------
// bpbcd_dabble
// Bit-serial shift-add-3 core: one value bit enters the BCD register per
// cycle, every digit of 5 or more gets 3 added before the shift.
// ----------------------------------------------------------------------------
module bpbcd_dabble (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bpbcd_pkg::VALUE_W-1:0] value_i,
  output bpbcd_pkg::dab_sts_t           sts_o,
  output logic [bpbcd_pkg::BCD_W-1:0]   bcd_o
);
  import bpbcd_pkg::*;

  logic [VALUE_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d, adj;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;

  // Correct each digit before the shift.
  always_comb begin
    for (int d = 0; d < BCD_DIGITS; d++) begin
      adj[d*DIGIT_W +: DIGIT_W] = (bcd_q[d*DIGIT_W +: DIGIT_W] >= 4'd5) ?
                                  bcd_q[d*DIGIT_W +: DIGIT_W] + 4'd3 :
                                  bcd_q[d*DIGIT_W +: DIGIT_W];
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = value_i;
      bcd_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d  = {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
      bin_d  = {bin_q[VALUE_W-2:0], 1'b0};
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(VALUE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign bcd_o      = bcd_q;

endmodule

// ----- src/binary_to_packed_bcd_unit.sv -----
// ----------------------------------------------------------------------------
// binary_to_packed_bcd_unit
// Converts an unsigned 64-bit value to a packed BCD field and streams it out
// one byte per beat, most significant byte first.
// ----------------------------------------------------------------------------
// One input beat carries a 64-bit value and a byte count (saturated to
// MaxBytes). The value is converted by a bit-serial shift-add-3 core that
// takes one value bit per cycle; the overflow flag is latched when the core
// signals done. The field is then emitted as one result beat per byte,
// byte 0 (most significant) first, high nibble holding the more significant
// digit, leading unused digits zero. The final beat has last set and carries
// overflow, which flags a value with more decimal digits than twice the byte
// count; the field then holds the low-order digits. A byte count of zero
// yields a single beat with has_byte low. Items are processed one at a time;
// the next input beat is taken as soon as the last result of the previous
// one sits in the output register, even if that beat has not been taken yet.
module binary_to_packed_bcd_unit #(
  parameter int unsigned MaxBytes = bpbcd_pkg::MAX_BYTES
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bpbcd_in_if.sink      in_i,
  bpbcd_out_if.source   out_o
);
  import bpbcd_pkg::*;

  localparam int unsigned CntW = $clog2(MaxBytes + 1);

  state_e             state_q, state_d;
  logic [CntW-1:0]    n_q, n_d;        // saturated byte count
  logic [CntW-1:0]    idx_q, idx_d;    // next byte position to emit
  logic [CntW-1:0]    n_sat, pair;
  logic               ovf_q, ovf_d, ovf_calc;
  logic               out_valid_q, out_valid_d;
  out_beat_t          out_data_q, out_data_d;
  logic               start;
  logic               last_byte;
  logic [BYTE_W-1:0]  pair_byte;
  logic [BCD_W-1:0]   bcd;
  dab_sts_t           dab_sts;

  bpbcd_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .value_i (in_i.data.value),
    .sts_o   (dab_sts),
    .bcd_o   (bcd)
  );

  // Clamp the requested field width.
  assign n_sat = (32'(in_i.data.byte_count) > MaxBytes) ? CntW'(MaxBytes)
                                                       : CntW'(in_i.data.byte_count);

  // Byte position idx maps to digit pair n-1-idx, counted from the LSB.
  assign pair      = n_q - idx_q - 1'b1;
  assign last_byte = (n_q == '0) || (idx_q == n_q - 1'b1);

  // Pairs beyond the 20 digits of a 64-bit value are always zero.
  always_comb begin
    pair_byte = '0;
    for (int k = 0; k < BCD_PAIRS; k++) begin
      if (32'(pair) == k) pair_byte = bcd[k*BYTE_W +: BYTE_W];
    end
  end

  // Overflow: any nonzero digit at or above position 2n.
  always_comb begin
    ovf_calc = 1'b0;
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if ((d >= 2 * 32'(n_q)) && (bcd[d*DIGIT_W +: DIGIT_W] != '0)) ovf_calc = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    idx_d       = idx_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    start       = 1'b0;
    in_i.ready  = 1'b0;

    // Drop the held beat once the sink takes it.
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          n_d     = n_sat;
          start   = 1'b1;
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        if (dab_sts.done) begin
          ovf_d   = ovf_calc;
          idx_d   = '0;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // Advance only when the output register is free or being emptied.
        if (!out_valid_q || out_o.ready) begin
          out_valid_d           = 1'b1;
          out_data_d.byte_index = INDEX_W'(idx_q);
          out_data_d.bcd_byte   = (n_q == '0) ? '0 : pair_byte;
          out_data_d.has_byte   = (n_q != '0);
          out_data_d.last       = last_byte;
          out_data_d.overflow   = last_byte & ovf_q;
          if (last_byte) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      idx_q       <= '0;
      ovf_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
      idx_q       <= idx_d;
      ovf_q       <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// ----- src/bpbcd_chk.sv -----
// ----------------------------------------------------------------------------
// bpbcd_chk
// Port-level checks of the binary to packed BCD converter, bound to the top.
// ----------------------------------------------------------------------------
module bpbcd_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input bpbcd_pkg::out_beat_t out_data_i
);
  import bpbcd_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result beat changed while stalled");

  // One item at a time: input closes right after a beat is taken.
  a_in_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input open during conversion");

  // Overflow only rides on the last beat.
  a_ovf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.last |-> !out_data_i.overflow)
    else $error("overflow on a non-final beat");

  // Both nibbles are decimal digits.
  a_bcd_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.bcd_byte[7:4] <= 4'd9 && out_data_i.bcd_byte[3:0] <= 4'd9)
    else $error("non-decimal nibble");

  // An empty beat is the sole, final beat of a zero-length field.
  a_empty_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.has_byte |->
      out_data_i.last && out_data_i.byte_index == '0 && out_data_i.bcd_byte == '0)
    else $error("malformed empty beat");

endmodule

bind binary_to_packed_bcd_unit bpbcd_chk u_bpbcd_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

// ----- bench/tb_binary_to_packed_bcd_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_to_packed_bcd_unit
// Self-checking bench for the binary to packed BCD converter. Each accepted
// conversion request is expanded into its packed BCD beats by a bench-side
// decimal expansion, and every result beat is compared field by field with
// the oldest pending beat. Directed cases cover field extremes, the zero
// count, count saturation and the overflow boundaries; random requests
// follow under three idle profiles on the input and output channels.
// ----------------------------------------------------------------------------
module tb_binary_to_packed_bcd_unit;
  import bpbcd_pkg::*;

  localparam int unsigned CLK_HALF    = 5;
  localparam int unsigned RESET_LEN   = 8;
  localparam int unsigned DRAIN_TAIL  = 120;      // longer than one 16-byte item
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned MAX_REPORTS = 10;

  logic clk_i;
  logic rst_ni;

  bpbcd_in_if  in_ch ();
  bpbcd_out_if out_ch ();

  binary_to_packed_bcd_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Beats still owed by the converter, oldest first.
  out_beat_t pending_beats[$];

  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned requests_sent;
  int unsigned beats_checked;
  int unsigned overflow_beats;
  int unsigned empty_beats;

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  // Stop a hung run; the limit is far above the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles, %0d beats still pending",
               cycle_count, pending_beats.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Decimal expansion on the bench side
  // --------------------------------------------------------------------------
  function automatic logic [VALUE_W-1:0] pow10(input int unsigned exp10);
    logic [VALUE_W-1:0] acc;
    acc = 64'd1;
    for (int k = 0; k < int'(exp10); k++) acc = acc * 64'd10;
    return acc;
  endfunction

  // Queue the beats one request must produce. Fill the field from its least
  // significant byte upward; whatever value is left over means overflow.
  function automatic void queue_packed_bcd(input logic [VALUE_W-1:0] value,
                                           input logic [COUNT_W-1:0] count);
    logic [VALUE_W-1:0] rest;
    logic [BYTE_W-1:0]  field [MAX_BYTES];
    int unsigned        n_bytes;
    out_beat_t          beat;
    n_bytes = (count > MAX_BYTES) ? MAX_BYTES : int'(count);
    rest    = value;
    beat    = '0;
    if (n_bytes == 0) begin
      // Zero count: one beat without payload, overflow on any nonzero value.
      beat.last     = 1'b1;
      beat.overflow = (value != 0);
      pending_beats.push_back(beat);
      return;
    end
    for (int i = int'(n_bytes) - 1; i >= 0; i--) begin
      field[i] = {4'((rest / 64'd10) % 64'd10), 4'(rest % 64'd10)};
      rest     = rest / 64'd100;
    end
    for (int i = 0; i < int'(n_bytes); i++) begin
      beat.byte_index = INDEX_W'(i);
      beat.bcd_byte   = field[i];
      beat.has_byte   = 1'b1;
      beat.last       = (i == int'(n_bytes) - 1);
      beat.overflow   = beat.last && (rest != 0);
      pending_beats.push_back(beat);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random back-pressure and the result check
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Compare each accepted result beat with the oldest pending beat.
  always @(posedge clk_i) begin
    out_beat_t got;
    out_beat_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      beats_checked++;
      if (got.overflow) overflow_beats++;
      if (!got.has_byte) empty_beats++;
      if (pending_beats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("[%0t] unexpected beat: idx=%0d byte=%h has=%b last=%b ovf=%b",
                   $realtime, got.byte_index, got.bcd_byte, got.has_byte,
                   got.last, got.overflow);
      end else begin
        want = pending_beats.pop_front();
        if (got.byte_index !== want.byte_index || got.bcd_byte !== want.bcd_byte ||
            got.has_byte !== want.has_byte || got.last !== want.last ||
            got.overflow !== want.overflow) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] beat mismatch: expected idx=%0d byte=%h has=%b last=%b ovf=%b",
                     $realtime, want.byte_index, want.bcd_byte, want.has_byte,
                     want.last, want.overflow);
            $display("    got idx=%0d byte=%h has=%b last=%b ovf=%b",
                     got.byte_index, got.bcd_byte, got.has_byte, got.last,
                     got.overflow);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offer one request and hold it until the converter takes it. Valid stays
  // high on return, so a back-to-back call only rewrites the payload.
  task automatic send_conversion(input logic [VALUE_W-1:0] value,
                                 input logic [COUNT_W-1:0] count);
    in_beat_t beat;
    beat.value      = value;
    beat.byte_count = count;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= beat;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    queue_packed_bcd(value, count);
    requests_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Smallest and largest values, narrow and wide fields, every decimal digit.
  task automatic test_field_extremes();
    send_conversion(64'd0, 5'd1);
    send_conversion(64'd0, 5'd16);
    send_conversion('1, 5'd16);
    send_conversion('1, 5'd10);                // exactly 20 digits: fits
    send_conversion('1, 5'd9);                 // one digit pair short
    send_conversion(64'd1234567890, 5'd5);
    send_conversion(64'd9876543210, 5'd5);
  endtask

  // Zero count: a single empty beat, overflow only for a nonzero value.
  task automatic test_zero_count();
    send_conversion(64'd0, 5'd0);
    send_conversion(64'd1, 5'd0);
    send_conversion('1, 5'd0);
  endtask

  // Counts past the limit clamp to the widest field.
  task automatic test_count_saturation();
    send_conversion('1, 5'd17);
    send_conversion(64'd123, 5'd31);
    send_conversion(64'd0, 5'd24);
  endtask

  // Largest value that fits, and the smallest that does not.
  task automatic test_overflow_boundaries();
    int unsigned widths [4] = '{1, 2, 5, 9};
    foreach (widths[k]) begin
      send_conversion(pow10(2 * widths[k]) - 64'd1, COUNT_W'(widths[k]));
      send_conversion(pow10(2 * widths[k]), COUNT_W'(widths[k]));
    end
  endtask

  // Mix of full-range values, values of a random digit length and values
  // right at a field boundary; counts mostly legal, some past the limit.
  task automatic test_random_conversions(input int unsigned n_requests);
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    int unsigned        shape;
    int unsigned        pairs;
    for (int r = 0; r < int'(n_requests); r++) begin
      shape = $urandom_range(9);
      if (shape < 3) begin
        value = {$urandom, $urandom};
      end else if (shape < 8) begin
        value = {$urandom, $urandom} % pow10($urandom_range(1, 19));
      end else begin
        pairs = $urandom_range(1, 9);
        value = pow10(2 * pairs) + 64'($urandom_range(2)) - 64'd1;
      end
      if ($urandom_range(9) == 0) count = COUNT_W'($urandom_range(17, 31));
      else                        count = COUNT_W'($urandom_range(0, 16));
      send_conversion(value, count);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni            = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.data        = '0;
    out_ch.ready      = 1'b0;
    cycle_count       = 0;
    mismatch_count    = 0;
    requests_sent     = 0;
    beats_checked     = 0;
    overflow_beats    = 0;
    empty_beats       = 0;
    sender_idle_pct   = 9;
    receiver_idle_pct = 73;

    repeat (RESET_LEN) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Light input gaps, heavy output back-pressure.
    test_field_extremes();
    test_zero_count();
    test_count_saturation();
    test_overflow_boundaries();
    test_random_conversions(53);

    // Swap the profiles: sparse input, mostly ready output.
    sender_idle_pct   = 73;
    receiver_idle_pct = 9;
    test_random_conversions(53);

    // Full rate on both sides.
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    test_random_conversions(53);

    // Drop valid, drain every pending beat, then watch for stray beats.
    in_ch.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);

    $display("Converted %0d requests into %0d checked beats (%0d with overflow, %0d empty).",
             requests_sent, beats_checked, overflow_beats, empty_beats);
    $display("Idle profiles 9/73, 73/9 and 0/0 percent; %0d mismatches.", mismatch_count);
    if (mismatch_count == 0 && pending_beats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/bpbcd_pkg.sv
src/bpbcd_if.sv
src/bpbcd_dabble.sv
src/binary_to_packed_bcd_unit.sv
src/bpbcd_chk.sv
bench/tb_binary_to_packed_bcd_unit.sv
